// File: sv/byterun1_bitplane_unpacker_unit_defines.svh
// ---------------------------------------------------------------------------
// Byte-run unpacker assertion macros
// Shared assertion helpers. They sample on clk and are disabled while
// arst_n is low, so they are meant for modules with those port names.
// ---------------------------------------------------------------------------
`ifndef BYTERUN1_BITPLANE_UNPACKER_UNIT_DEFINES_SVH
`define BYTERUN1_BITPLANE_UNPACKER_UNIT_DEFINES_SVH

// Condition in the same cycle: when ante holds, cons must hold as well.
`define BR1BPU_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Implication across an edge: when ante holds, cons must hold at the next edge.
`define BR1BPU_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: sv/br1bpu_pkg.sv
// ---------------------------------------------------------------------------
// Byte-run unpacker package
// Widths, register map, decoder phase codes and the structs passed between
// the top level and the decode step.
// ---------------------------------------------------------------------------
`default_nettype none

package br1bpu_pkg;

	// Field and counter widths.
	localparam int DIM_W  = 13;   // image width / height registers
	localparam int PC_W   = 6;    // plane count register
	localparam int RB_W   = 13;   // bytes per plane row
	localparam int DP_W   = 6;    // effective plane depth
	localparam int RBD_W  = 16;   // data bytes per row (row bytes times depth)
	localparam int ROW_W  = 17;   // raw row length including mask and pad
	localparam int TOT_W  = 30;   // image size and bytes written
	localparam int COL_W  = 16;   // saturating column counter
	localparam int PI_W   = 7;    // saturating plane index
	localparam int LIT_W  = 8;    // literal or run length
	localparam int BYTE_W = 8;
	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;
	localparam int IDX_W  = 3;

	// Register indexes (byte address is four times the index).
	localparam logic [IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
	localparam logic [IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
	localparam logic [IDX_W-1:0] REG_IMAGE_KIND   = 3'd2;
	localparam logic [IDX_W-1:0] REG_PLANE_COUNT  = 3'd3;
	localparam logic [IDX_W-1:0] REG_MASK_PLANE   = 3'd4;
	localparam logic [IDX_W-1:0] REG_COMPRESSED   = 3'd5;

	// Register reset values.
	localparam logic [DIM_W-1:0] RST_IMAGE_WIDTH  = 13'd1;
	localparam logic [DIM_W-1:0] RST_IMAGE_HEIGHT = 13'd1;
	localparam logic             RST_IMAGE_KIND   = 1'b0;
	localparam logic [PC_W-1:0]  RST_PLANE_COUNT  = 6'd8;
	localparam logic             RST_MASK_PLANE   = 1'b0;
	localparam logic             RST_COMPRESSED   = 1'b1;

	// Derived sizes for the reset configuration (one pixel, one plane).
	localparam logic [RBD_W-1:0] RST_DATA_LEN = 16'd1;
	localparam logic [TOT_W-1:0] RST_TOTAL    = 30'd1;
	localparam logic [ROW_W-1:0] RST_ROW_LEN  = 17'd2;

	// Byte-run command that does nothing.
	localparam logic [BYTE_W-1:0] CMD_NOP = 8'd128;

	// Plane index saturates here, above any reachable plane count.
	localparam logic [PI_W-1:0] PI_MAX = 7'd127;

	typedef enum logic [1:0] {
		PH_CMD = 2'd0,
		PH_LIT = 2'd1,
		PH_REP = 2'd2
	} phase_t;

	// Effective configuration as seen by the decode step.
	typedef struct packed {
		logic [RB_W-1:0]  row_bytes;
		logic [DP_W-1:0]  depth;
		logic             mask_present;
		logic             compressed;
		logic [RBD_W-1:0] data_len;
		logic [ROW_W-1:0] row_len;
		logic [TOT_W-1:0] total;
	} cfg_t;

	// Decoder state.
	typedef struct packed {
		phase_t           phase;
		logic [LIT_W-1:0] literal_left;
		logic [COL_W-1:0] column_bytes;
		logic [PI_W-1:0]  plane_index;
		logic             skipping_mask;
		logic [TOT_W-1:0] bytes_written;
		logic [ROW_W-1:0] row_offset;
	} state_t;

	// One result of a decode step.
	typedef struct packed {
		logic              emit;
		logic [BYTE_W-1:0] value;
		logic [LIT_W-1:0]  count;
		logic              done;
	} result_t;

endpackage

`default_nettype wire

// File: sv/br1bpu_step.sv
// ---------------------------------------------------------------------------
// Byte-run unpacker decode step
// Combinational next-state and result logic for one body byte: raw row
// copying, byte-run command decode, plane and mask tracking, and clipping
// of the last run at the image size.
// ---------------------------------------------------------------------------
`default_nettype none

module br1bpu_step (
	input  br1bpu_pkg::cfg_t            cfg,
	input  br1bpu_pkg::state_t          st,
	input  logic [br1bpu_pkg::BYTE_W-1:0] body_byte,
	output br1bpu_pkg::state_t          nxt,
	output br1bpu_pkg::result_t         res
);
	import br1bpu_pkg::*;

	logic             clr;
	state_t           s;
	logic [ROW_W-1:0] ro1;
	logic [PI_W-1:0]  pi1;
	logic             wrap;
	logic [COL_W:0]   col_sum;
	logic [LIT_W-1:0] run_n;
	logic             emit;
	logic [LIT_W-1:0] n;
	logic [TOT_W-1:0] rem;
	logic             hit_end;

	always_comb begin
		// A finished image (or one shrunk by a register write) starts over.
		clr = (st.bytes_written >= cfg.total);
		s = clr ? '0 : st;

		nxt = s;
		emit = 1'b0;
		n = LIT_W'(1);
		ro1 = '0;
		pi1 = '0;
		wrap = 1'b0;
		col_sum = '0;
		run_n = '0;

		if (!cfg.compressed) begin
			// Raw rows: copy data bytes, drop mask and pad bytes.
			ro1 = s.row_offset + ROW_W'(1);
			nxt.row_offset = (ro1 >= cfg.row_len) ? '0 : ro1;
			emit = (s.row_offset < ROW_W'(cfg.data_len));
		end else begin
			case (s.phase)
				PH_LIT: begin
					nxt.literal_left = (s.literal_left != '0) ?
						s.literal_left - LIT_W'(1) : '0;
					if (nxt.literal_left == '0) nxt.phase = PH_CMD;
					emit = !s.skipping_mask;
				end
				PH_REP: begin
					nxt.phase = PH_CMD;
					nxt.literal_left = '0;
					emit = !s.skipping_mask;
					n = s.literal_left;
				end
				default: begin
					// A plane ends when its column count lands exactly on the row size.
					if (s.column_bytes == COL_W'(cfg.row_bytes)) begin
						pi1 = (s.plane_index == PI_MAX) ? PI_MAX : s.plane_index + PI_W'(1);
						wrap = (!cfg.mask_present && pi1 == PI_W'(cfg.depth)) ||
							(cfg.mask_present && pi1 == PI_W'(cfg.depth) + PI_W'(1));
						if (wrap) begin
							nxt.skipping_mask = 1'b0;
							nxt.plane_index = '0;
						end else begin
							nxt.plane_index = pi1;
						end
						if (cfg.mask_present && nxt.plane_index == PI_W'(cfg.depth)) begin
							nxt.skipping_mask = 1'b1;
						end
						nxt.column_bytes = '0;
					end

					// Command decode: literal count, run length or no-op.
					nxt.phase = PH_CMD;
					if (body_byte < CMD_NOP) begin
						run_n = body_byte + LIT_W'(1);
						nxt.phase = PH_LIT;
					end else if (body_byte > CMD_NOP) begin
						run_n = LIT_W'(9'd257 - {1'b0, body_byte});
						nxt.phase = PH_REP;
					end
					if (body_byte != CMD_NOP) begin
						nxt.literal_left = run_n;
						col_sum = {1'b0, nxt.column_bytes} + (COL_W + 1)'(run_n);
						nxt.column_bytes = col_sum[COL_W] ? '1 : col_sum[COL_W-1:0];
					end
				end
			endcase
		end

		// Clip the result at the image end; the state then starts over.
		rem = cfg.total - s.bytes_written;
		hit_end = (TOT_W'(n) >= rem);
		res.emit = emit;
		res.value = body_byte;
		res.count = hit_end ? rem[LIT_W-1:0] : n;
		res.done = emit && hit_end;
		if (emit) begin
			nxt.bytes_written = s.bytes_written + TOT_W'(n);
			if (hit_end) nxt = '0;
		end
	end

endmodule

`default_nettype wire

// File: sv/byterun1_bitplane_unpacker_unit.sv
// Throughput: one body byte per cycle while out_stall does not hold the result register;
// the decode state is updated as a byte moves from the input register to the result register.
// Reset: arst_n clears the decoder state and both stage valids, and loads
// the register defaults; the derived image size is ready at once.
// ---------------------------------------------------------------------------
// Byte-run bitplane unpacker, top level
// Decodes an image body, raw or byte-run coded, into value and repeat
// results, with an APB-style register port for the image geometry.
// ---------------------------------------------------------------------------
`default_nettype none

`include "byterun1_bitplane_unpacker_unit_defines.svh"

module byterun1_bitplane_unpacker_unit #(
	parameter int MAX_DIM    = 4096,
	parameter int MAX_PLANES = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// Register port
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [br1bpu_pkg::ADDR_W-1:0]   paddr,
	input  logic [br1bpu_pkg::DATA_W-1:0]   pwdata,
	output logic [br1bpu_pkg::DATA_W-1:0]   prdata,
	output logic                            pready,
	// Body byte input
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [br1bpu_pkg::BYTE_W-1:0]   body_byte,
	// Result output
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [br1bpu_pkg::BYTE_W-1:0]   pixel_value,
	output logic [br1bpu_pkg::LIT_W-1:0]    repeat_count,
	output logic                            image_done
);
	import br1bpu_pkg::*;

	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
		if (v == '0) return DIM_W'(1);
		if (32'(v) > 32'(MAX_DIM)) return DIM_W'(MAX_DIM);
		return v;
	endfunction

	function automatic logic [DP_W-1:0] depth_of(input logic kind,
		input logic [PC_W-1:0] pc);
		if (!kind) return DP_W'(1);
		if (pc == '0) return DP_W'(1);
		if (32'(pc) > 32'(MAX_PLANES)) return DP_W'(MAX_PLANES);
		return DP_W'(pc);
	endfunction

	function automatic logic [RB_W-1:0] row_bytes_of(input logic [DIM_W-1:0] w,
		input logic kind);
		logic [DIM_W:0] up;
		up = (DIM_W + 1)'(w) + (DIM_W + 1)'(7);
		return kind ? RB_W'(up >> 3) : RB_W'(w);
	endfunction

	// Configuration registers.
	logic [DIM_W-1:0] width_q;
	logic [DIM_W-1:0] height_q;
	logic             kind_q;
	logic [PC_W-1:0]  planes_q;
	logic             mask_q;
	logic             comp_q;

	logic [IDX_W-1:0] reg_idx;
	logic             wr_sel;
	logic             wr_en;

	// Candidate configuration: registers with a pending write overlaid.
	logic [DIM_W-1:0] cand_width;
	logic [DIM_W-1:0] cand_height;
	logic             cand_kind;
	logic [PC_W-1:0]  cand_planes;
	logic             cand_mask;
	logic [DIM_W-1:0] c_w_eff;
	logic [DIM_W-1:0] c_h_eff;
	logic [RB_W-1:0]  c_rb;
	logic [DP_W-1:0]  c_dp;
	logic [RB_W+DP_W-1:0]   rbd_full;
	logic [DIM_W+RBD_W-1:0] tot_full;

	logic [RBD_W-1:0] rbd_q;
	logic [TOT_W-1:0] total_q;
	logic [ROW_W-1:0] row_len_q;

	// Pipeline.
	logic                s1_valid_s1;
	logic [BYTE_W-1:0]   byte_s1;
	logic                advance;
	logic                proc;
	cfg_t                cfg;
	state_t              st_q;
	state_t              st_nxt;
	result_t             res;
	logic                out_valid_q;
	logic [BYTE_W-1:0]   pixel_value_q;
	logic [LIT_W-1:0]    repeat_count_q;
	logic                image_done_q;

	assign pready  = 1'b1;
	assign reg_idx = paddr[ADDR_W-1:2];
	assign wr_sel  = psel && pwrite;
	assign wr_en   = psel && penable && pwrite && pready;

	// Register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= RST_IMAGE_WIDTH;
			height_q <= RST_IMAGE_HEIGHT;
			kind_q   <= RST_IMAGE_KIND;
			planes_q <= RST_PLANE_COUNT;
			mask_q   <= RST_MASK_PLANE;
			comp_q   <= RST_COMPRESSED;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_IMAGE_WIDTH:  width_q  <= pwdata[DIM_W-1:0];
				REG_IMAGE_HEIGHT: height_q <= pwdata[DIM_W-1:0];
				REG_IMAGE_KIND:   kind_q   <= pwdata[0];
				REG_PLANE_COUNT:  planes_q <= pwdata[PC_W-1:0];
				REG_MASK_PLANE:   mask_q   <= pwdata[0];
				REG_COMPRESSED:   comp_q   <= pwdata[0];
				default: ;
			endcase
		end
	end

	// Register reads.
	always_comb begin
		unique case (reg_idx)
			REG_IMAGE_WIDTH:  prdata = DATA_W'(width_q);
			REG_IMAGE_HEIGHT: prdata = DATA_W'(height_q);
			REG_IMAGE_KIND:   prdata = DATA_W'(kind_q);
			REG_PLANE_COUNT:  prdata = DATA_W'(planes_q);
			REG_MASK_PLANE:   prdata = DATA_W'(mask_q);
			REG_COMPRESSED:   prdata = DATA_W'(comp_q);
			default:          prdata = '0;
		endcase
	end

	// The write data is stable from the setup cycle on, so the two size
	// products follow it and are final at the same edge as the register.
	always_comb begin
		cand_width  = (wr_sel && reg_idx == REG_IMAGE_WIDTH)  ? pwdata[DIM_W-1:0] : width_q;
		cand_height = (wr_sel && reg_idx == REG_IMAGE_HEIGHT) ? pwdata[DIM_W-1:0] : height_q;
		cand_kind   = (wr_sel && reg_idx == REG_IMAGE_KIND)   ? pwdata[0] : kind_q;
		cand_planes = (wr_sel && reg_idx == REG_PLANE_COUNT)  ? pwdata[PC_W-1:0] : planes_q;
		cand_mask   = (wr_sel && reg_idx == REG_MASK_PLANE)   ? pwdata[0] : mask_q;
		c_w_eff  = clamp_dim(cand_width);
		c_h_eff  = clamp_dim(cand_height);
		c_rb     = row_bytes_of(c_w_eff, cand_kind);
		c_dp     = depth_of(cand_kind, cand_planes);
		rbd_full = c_rb * c_dp;
		tot_full = c_h_eff * rbd_q;
	end

	// Size products: row data bytes first, then image size and raw row length.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rbd_q     <= RST_DATA_LEN;
			total_q   <= RST_TOTAL;
			row_len_q <= RST_ROW_LEN;
		end else begin
			rbd_q     <= rbd_full[RBD_W-1:0];
			total_q   <= TOT_W'(tot_full);
			row_len_q <= ROW_W'(rbd_q) + (cand_mask ? ROW_W'(c_rb) : '0) +
				ROW_W'(c_w_eff[0]);
		end
	end

	// Effective configuration for the decode step.
	always_comb begin
		cfg.row_bytes    = row_bytes_of(clamp_dim(width_q), kind_q);
		cfg.depth        = depth_of(kind_q, planes_q);
		cfg.mask_present = mask_q;
		cfg.compressed   = comp_q;
		cfg.data_len     = rbd_q;
		cfg.row_len      = row_len_q;
		cfg.total        = total_q;
	end

	// Handshake: the input stage moves whenever the result register can load.
	assign advance  = !out_valid_q || !out_stall;
	assign proc     = s1_valid_s1 && advance;
	assign in_stall = s1_valid_s1 && !advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			s1_valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) byte_s1 <= body_byte;
	end

	br1bpu_step u_step (
		.cfg       (cfg),
		.st        (st_q),
		.body_byte (byte_s1),
		.nxt       (st_nxt),
		.res       (res)
	);

	// Decoder state advances once per processed byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (proc) begin
			st_q <= st_nxt;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= proc && res.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (proc && res.emit) begin
			pixel_value_q  <= res.value;
			repeat_count_q <= res.count;
			image_done_q   <= res.done;
		end
	end

	assign out_valid    = out_valid_q;
	assign pixel_value  = pixel_value_q;
	assign repeat_count = repeat_count_q;
	assign image_done   = image_done_q;

	// A byte taken into a full input stage must be matched by one leaving it.
	`BR1BPU_ASSERT_SAME(a_no_overwrite, in_valid && !in_stall && s1_valid_s1, advance, "input stage overwritten")
	// A run is never empty and never longer than one command allows.
	`BR1BPU_ASSERT_SAME(a_count_range, out_valid_q, repeat_count_q != '0 && repeat_count_q <= 8'd128, "repeat count out of range")
	// The result that completes an image leaves the decoder in its initial state.
	`BR1BPU_ASSERT_NEXT(a_done_clears, proc && res.emit && res.done, st_q == '0, "state not cleared after image end")

endmodule

`default_nettype wire

// File: dv/tb_top.sv
// ---------------------------------------------------------------------------
// Byte-run bitplane unpacker testbench
// Drives body bytes into the unpacker, predicts every value and repeat
// transfer from its own copy of the decoder and the image geometry, and
// checks each result transfer in order. Directed cases come first, then
// random images under changing geometry, idling and a long output hold-off.
// ---------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import br1bpu_pkg::*;

	localparam int MAX_DIM      = 4096;
	localparam int MAX_PLANES   = 32;
	localparam int CLK_PERIOD   = 20;
	localparam int RESET_CYCLES = 8;
	localparam int DRAIN_CYCLES = 8;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int IMAGE_BUDGET = 250;
	localparam int MAX_REPORTS  = 200;
	localparam int PHASE_ITEMS  = 520;
	localparam int HOLD_CYCLES  = 300;

	// One decoded run as it leaves the block.
	typedef struct packed {
		logic [BYTE_W-1:0] value;
		logic [LIT_W-1:0]  count;
		logic              done;
	} pixel_run_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                psel = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite = 1'b0;
	logic [ADDR_W-1:0]   paddr = '0;
	logic [DATA_W-1:0]   pwdata = '0;
	logic [DATA_W-1:0]   prdata;
	logic                pready;
	logic                in_valid = 1'b0;
	logic                in_stall;
	logic [BYTE_W-1:0]   body_byte = '0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic [BYTE_W-1:0]   pixel_value;
	logic [LIT_W-1:0]    repeat_count;
	logic                image_done;

	// Geometry as the block should see it.
	logic [DIM_W-1:0] cfg_width = RST_IMAGE_WIDTH;
	logic [DIM_W-1:0] cfg_height = RST_IMAGE_HEIGHT;
	logic             cfg_kind = RST_IMAGE_KIND;
	logic [PC_W-1:0]  cfg_planes = RST_PLANE_COUNT;
	logic             cfg_mask = RST_MASK_PLANE;
	logic             cfg_compressed = RST_COMPRESSED;

	// Decoder state of the prediction.
	phase_t            dec_phase = PH_CMD;
	int unsigned       run_left = 0;
	int unsigned       col_bytes = 0;
	int unsigned       plane_idx = 0;
	bit                in_mask = 1'b0;
	longint unsigned   written = 0;
	int unsigned       raw_pos = 0;
	bit                image_finished = 1'b0;

	pixel_run_t        expected_runs[$];
	int unsigned       error_count = 0;
	int unsigned       items_sent = 0;
	int unsigned       cycle_count = 0;
	int unsigned       src_gap_pct = 17;
	int unsigned       sink_gap_pct = 56;
	int unsigned       sink_hold_left = 0;

	byterun1_bitplane_unpacker_unit #(
		.MAX_DIM(MAX_DIM),
		.MAX_PLANES(MAX_PLANES)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.body_byte(body_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.pixel_value(pixel_value),
		.repeat_count(repeat_count),
		.image_done(image_done)
	);

	// Free-running clock.
	always begin
		#(CLK_PERIOD / 2) clk = 1'b1;
		#(CLK_PERIOD / 2) clk = 1'b0;
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("watchdog expired after %0d cycles", cycle_count);
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Geometry helpers
	// ------------------------------------------------------------------
	function automatic int unsigned eff_dim(input logic [DIM_W-1:0] v);
		if (v == 0) return 1;
		return (v > MAX_DIM) ? MAX_DIM : v;
	endfunction

	function automatic int unsigned row_bytes();
		int unsigned w;
		w = eff_dim(cfg_width);
		return cfg_kind ? (w + 7) / 8 : w;
	endfunction

	function automatic int unsigned plane_depth();
		if (!cfg_kind || cfg_planes == 0) return 1;
		return (cfg_planes > MAX_PLANES) ? MAX_PLANES : cfg_planes;
	endfunction

	function automatic longint unsigned image_size();
		return 64'(eff_dim(cfg_height)) * row_bytes() * plane_depth();
	endfunction

	// ------------------------------------------------------------------
	// Decoder prediction
	// ------------------------------------------------------------------
	function automatic void clear_decoder();
		dec_phase = PH_CMD;
		run_left = 0;
		col_bytes = 0;
		plane_idx = 0;
		in_mask = 1'b0;
		written = 0;
		raw_pos = 0;
	endfunction

	function automatic bit decoder_idle();
		return dec_phase == PH_CMD && run_left == 0 && col_bytes == 0 && plane_idx == 0
			&& !in_mask && written == 0 && raw_pos == 0;
	endfunction

	// Queue one run, cut at the end of the image; the image end resets the decoder.
	function automatic void emit_run(input logic [BYTE_W-1:0] v, input int unsigned n);
		longint unsigned total;
		longint unsigned room;
		int unsigned     cnt;
		pixel_run_t      r;
		total = image_size();
		room = (total > written) ? total - written : 1;
		cnt = (n > room) ? int'(room) : n;
		written += cnt;
		r.value = v;
		r.count = cnt[LIT_W-1:0];
		r.done = (written >= total);
		expected_runs.push_back(r);
		if (r.done) begin
			image_finished = 1'b1;
			clear_decoder();
		end
	endfunction

	function automatic void predict_body_byte(input logic [BYTE_W-1:0] b);
		int unsigned data_len;
		int unsigned row_len;
		int unsigned pos;
		int unsigned n;
		int unsigned dp;

		if (written >= image_size()) clear_decoder();

		// Raw rows: data bytes pass, mask and pad bytes are dropped.
		if (!cfg_compressed) begin
			data_len = row_bytes() * plane_depth();
			row_len = data_len + (cfg_mask ? row_bytes() : 0) + (eff_dim(cfg_width) & 1);
			pos = raw_pos;
			raw_pos++;
			if (raw_pos >= row_len) raw_pos = 0;
			if (pos < data_len) emit_run(b, 1);
			return;
		end

		case (dec_phase)
			PH_LIT: begin
				if (run_left > 0) run_left--;
				if (run_left == 0) dec_phase = PH_CMD;
				if (!in_mask) emit_run(b, 1);
			end
			PH_REP: begin
				n = run_left;
				dec_phase = PH_CMD;
				run_left = 0;
				if (!in_mask) emit_run(b, n);
			end
			default: begin
				// A plane ends only when its column count hits the row size exactly.
				if (col_bytes == row_bytes()) begin
					dp = plane_depth();
					plane_idx++;
					if ((plane_idx == dp && !cfg_mask) || (plane_idx == dp + 1 && cfg_mask)) begin
						in_mask = 1'b0;
						plane_idx = 0;
					end
					if (cfg_mask && plane_idx == dp) in_mask = 1'b1;
					col_bytes = 0;
				end
				dec_phase = PH_CMD;
				n = 0;
				if (b < CMD_NOP) begin
					run_left = b + 1;
					dec_phase = PH_LIT;
					n = b + 1;
				end else if (b > CMD_NOP) begin
					run_left = 257 - b;
					dec_phase = PH_REP;
					n = 257 - b;
				end
				col_bytes = (col_bytes + n > 16'hFFFF) ? 16'hFFFF : col_bytes + n;
			end
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Result checking
	// ------------------------------------------------------------------
	task automatic report_mismatch(input string what, input int unsigned got,
			input int unsigned want);
		error_count++;
		if (error_count <= MAX_REPORTS)
			$display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
	endtask

	always @(posedge clk) begin
		pixel_run_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_runs.size() == 0) begin
				report_mismatch("transfer with nothing expected, pixel_value", pixel_value, 0);
			end else begin
				want = expected_runs.pop_front();
				if (pixel_value !== want.value)
					report_mismatch("pixel_value", pixel_value, want.value);
				if (repeat_count !== want.count)
					report_mismatch("repeat_count", repeat_count, want.count);
				if (image_done !== want.done)
					report_mismatch("image_done", image_done, want.done);
			end
		end
	end

	// Receiver: random stalls, or a counted hold-off when one is requested.
	always @(negedge clk) begin
		if (sink_hold_left > 0) begin
			out_stall <= 1'b1;
			sink_hold_left = sink_hold_left - 1;
		end else begin
			out_stall <= ($urandom_range(99) < sink_gap_pct);
		end
	end

	// ------------------------------------------------------------------
	// Drivers
	// ------------------------------------------------------------------
	// Offer one body byte, with random gaps, and predict it once transferred.
	task automatic push_body_byte(input logic [BYTE_W-1:0] b);
		@(negedge clk);
		while ($urandom_range(99) < src_gap_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		body_byte <= b;
		do @(posedge clk); while (in_stall);
		predict_body_byte(b);
		items_sent++;
	endtask

	// Stop offering bytes, let every result drain, then allow for the pipeline.
	task automatic wait_for_idle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_runs.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic apb_write(input logic [IDX_W-1:0] idx, input int unsigned value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			REG_IMAGE_WIDTH:  cfg_width = value[DIM_W-1:0];
			REG_IMAGE_HEIGHT: cfg_height = value[DIM_W-1:0];
			REG_IMAGE_KIND:   cfg_kind = value[0];
			REG_PLANE_COUNT:  cfg_planes = value[PC_W-1:0];
			REG_MASK_PLANE:   cfg_mask = value[0];
			REG_COMPRESSED:   cfg_compressed = value[0];
			default: ;
		endcase
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic program_image(input int unsigned w, input int unsigned h,
			input int unsigned kind, input int unsigned planes,
			input int unsigned mask, input int unsigned comp);
		wait_for_idle();
		apb_write(REG_IMAGE_WIDTH, w);
		apb_write(REG_IMAGE_HEIGHT, h);
		apb_write(REG_IMAGE_KIND, kind);
		apb_write(REG_PLANE_COUNT, planes);
		apb_write(REG_MASK_PLANE, mask);
		apb_write(REG_COMPRESSED, comp);
	endtask

	// Bring the decoder back to its start state on a one-byte image.
	task automatic flush_decoder();
		if (!decoder_idle()) begin
			program_image(1, 1, 0, 8, 0, 1);
			while (!decoder_idle()) push_body_byte(8'hFF);
		end
	endtask

	// Send one image body: random raw bytes, or byte-run coded planes with
	// random content and an occasional stray command.
	task automatic send_image();
		int unsigned start;
		int unsigned left;
		int unsigned len;
		int unsigned k;
		image_finished = 1'b0;
		start = items_sent;
		while (!image_finished && items_sent - start < IMAGE_BUDGET) begin
			if (!cfg_compressed) begin
				push_body_byte(8'($urandom));
			end else begin
				left = row_bytes();
				while (left > 0 && !image_finished && items_sent - start < IMAGE_BUDGET) begin
					if ($urandom_range(19) == 0) push_body_byte(CMD_NOP);
					if ($urandom_range(29) == 0) begin
						push_body_byte(8'($urandom));
						left = 0;
					end else begin
						if ($urandom_range(1))
							len = $urandom_range(1, (left < 4) ? left : 4);
						else
							len = $urandom_range(1, (left < 128) ? left : 128);
						if (len >= 2 && $urandom_range(1)) begin
							push_body_byte(8'(257 - len));
							push_body_byte(8'($urandom));
						end else begin
							push_body_byte(8'(len - 1));
							for (k = 0; k < len && !image_finished; k++)
								push_body_byte(8'($urandom));
						end
						left -= len;
					end
				end
			end
		end
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------
	// Reset geometry is a single pixel: a no-op command, a literal, and a
	// long run that is cut to the image size.
	task automatic test_reset_defaults();
		push_body_byte(CMD_NOP);
		push_body_byte(8'h00);
		push_body_byte(8'hC3);
		push_body_byte(8'h81);
		push_body_byte(8'h3C);
	endtask

	// Raw planar row with a mask plane and a pad byte for the odd width.
	task automatic test_raw_mask_and_pad();
		program_image(1, 2, 1, 1, 1, 0);
		push_body_byte(8'h5A);
		push_body_byte(8'hFF);
		push_body_byte(8'h00);
		push_body_byte(8'hA5);
	endtask

	// A literal overshoots the row, so the plane never ends and the final
	// run is cut at the image end.
	task automatic test_run_past_row();
		program_image(2, 2, 0, 1, 0, 1);
		push_body_byte(8'h02);
		push_body_byte(8'h11);
		push_body_byte(8'h22);
		push_body_byte(8'h33);
		push_body_byte(8'hFE);
		push_body_byte(8'h44);
	endtask

	// Shrinking the height mid-image to no more than the bytes already written
	// restarts the decoder on the next byte.
	task automatic test_register_write_midimage();
		program_image(4, 4, 0, 1, 0, 1);
		push_body_byte(8'hFD);
		push_body_byte(8'h5A);
		wait_for_idle();
		apb_write(REG_IMAGE_HEIGHT, 1);
		push_body_byte(8'h00);
		push_body_byte(8'hA5);
	endtask

	// Zero and out-of-range sizes act as their clamped values.
	task automatic test_size_extremes();
		program_image(0, 8191, 1, 63, 1, 1);
		push_body_byte(8'h81);
		push_body_byte(8'h3C);
		program_image(8191, 1, 0, 0, 0, 1);
		push_body_byte(8'h81);
		push_body_byte(8'hC3);
		program_image(9, 0, 1, 0, 1, 0);
		push_body_byte(8'h01);
		push_body_byte(8'h80);
	endtask

	// Random geometries, a few images each, mostly small.
	task automatic test_random_images(input int unsigned src_pct, input int unsigned sink_pct,
			input int unsigned goal);
		int unsigned start;
		int unsigned w;
		int unsigned h;
		int unsigned planes;
		int unsigned n;
		bit          broken;
		src_gap_pct = src_pct;
		sink_gap_pct = sink_pct;
		start = items_sent;
		flush_decoder();
		while (items_sent - start < goal) begin
			w = ($urandom_range(19) == 0) ? $urandom_range(0, 8191) : $urandom_range(1, 40);
			h = ($urandom_range(19) == 0) ? $urandom_range(0, 8191) : $urandom_range(1, 4);
			planes = ($urandom_range(9) == 0) ? $urandom_range(0, 63) : $urandom_range(1, 6);
			program_image(w, h, $urandom_range(1), planes, $urandom_range(1),
				$urandom_range(3) != 0);
			n = $urandom_range(1, 3);
			broken = 1'b0;
			while (n > 0 && !broken) begin
				send_image();
				if (!decoder_idle()) begin
					flush_decoder();
					broken = 1'b1;
				end
				n--;
			end
		end
	endtask

	// The receiver holds off while the sender keeps offering a raw image,
	// so the block fills up and stalls its input.
	task automatic test_stall_fill();
		src_gap_pct = 0;
		program_image(16, 8, 0, 1, 0, 0);
		sink_hold_left = HOLD_CYCLES;
		send_image();
	endtask

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_defaults();
		test_raw_mask_and_pad();
		test_run_past_row();
		test_register_write_midimage();
		test_size_extremes();
		test_random_images(17, 56, PHASE_ITEMS);
		test_stall_fill();
		test_random_images(56, 17, PHASE_ITEMS);
		test_random_images(0, 0, PHASE_ITEMS);

		wait_for_idle();
		if (error_count == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

// File: byterun1_bitplane_unpacker_unit.f
+incdir+sv
sv/br1bpu_pkg.sv
sv/br1bpu_step.sv
sv/byterun1_bitplane_unpacker_unit.sv
dv/tb_top.sv
